// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define NPS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled during reset
`define NPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/nps_pkg.sv =====
package nps_pkg;

    localparam int MAX_PROCESSES_DEF = 16;
    localparam int TIME_W            = 21;
    localparam int ARR_W             = 16;
    localparam int BURST_W           = 16;
    localparam int PRIO_W            = 8;
    localparam int JOBNUM_W          = 5;
    localparam int PADDR_W           = 3;
    localparam int PDATA_W           = 32;

    localparam logic [TIME_W-1:0]  TIME_MAX     = {TIME_W{1'b1}};
    localparam logic [PADDR_W-1:0] CFG_ADDR_HNF = 3'd0;

    typedef struct packed {
        logic [ARR_W-1:0]   arrival_time;
        logic [BURST_W-1:0] burst_time;
        logic [PRIO_W-1:0]  job_priority;
        logic               last_job;
    } t_in_item;

    typedef struct packed {
        logic [JOBNUM_W-1:0] job_number;
        logic [TIME_W-1:0]   start_time;
        logic [TIME_W-1:0]   finish_time;
        logic                final_entry;
        logic                capacity_overflow;
    } t_out_item;

    typedef struct packed {
        logic [ARR_W-1:0]   arrival_time;
        logic [BURST_W-1:0] burst_time;
        logic [PRIO_W-1:0]  job_priority;
    } t_job;

    localparam int JOB_W = $bits(t_job);

    typedef struct packed {
        logic load;
        logic rd_en;
        logic commit;
        logic advance;
        logic last_emit;
    } t_ctl_cmd;

    typedef struct packed {
        logic best_found;
        logic out_free;
    } t_dp_status;

endpackage

// ===== src/nps_ram.sv =====
module nps_ram #(
    parameter int WIDTH = nps_pkg::JOB_W,
    parameter int DEPTH = nps_pkg::MAX_PROCESSES_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                      i_wr_data,
    input  logic                                  i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                      o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

// ===== src/nps_ctrl.sv =====
`include "assert_macros.svh"

module nps_ctrl #(
    parameter int MAX_PROCESSES = nps_pkg::MAX_PROCESSES_DEF,
    localparam int IDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1,
    localparam int CNT_W = $clog2(MAX_PROCESSES + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_last_job,
    output logic               o_in_ready,
    input  logic [CNT_W-1:0]   i_count,
    input  nps_pkg::t_dp_status i_status,
    output nps_pkg::t_ctl_cmd  o_cmd,
    output logic [IDX_W-1:0]   o_rd_idx
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_WAIT,
        S_DECIDE
    } t_state;

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_idx, n_idx;
    logic [CNT_W-1:0]  r_emit_cnt, n_emit_cnt;
    logic              w_in_acc;
    logic              w_scan_end;
    logic              w_last_emit;

    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_scan_end  = (CNT_W'(r_idx) + CNT_W'(1)) == i_count;
    assign w_last_emit = (r_emit_cnt + CNT_W'(1)) == i_count;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_rd_idx    = r_idx;

    always_comb begin
        n_state        = r_state;
        n_idx          = r_idx;
        n_emit_cnt     = r_emit_cnt;
        o_cmd          = '0;
        o_cmd.last_emit = w_last_emit;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    o_cmd.load = 1'b1;
                    if (i_last_job) begin
                        n_state    = S_SCAN;
                        n_idx      = '0;
                        n_emit_cnt = '0;
                    end
                end
            end
            S_SCAN: begin
                o_cmd.rd_en = 1'b1;
                if (w_scan_end) begin
                    n_state = S_WAIT;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_WAIT: begin
                n_state = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_status.best_found) begin
                    if (i_status.out_free) begin
                        o_cmd.commit = 1'b1;
                        n_emit_cnt   = r_emit_cnt + CNT_W'(1);
                        n_idx        = '0;
                        n_state      = w_last_emit ? S_IDLE : S_SCAN;
                    end
                end else begin
                    o_cmd.advance = 1'b1;
                    n_idx         = '0;
                    n_state       = S_SCAN;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_idx      <= '0;
            r_emit_cnt <= '0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_emit_cnt <= n_emit_cnt;
        end
    end

    `NPS_ASSERT_IMPL(a_scan_in_range, i_clk, i_rst_n,
        r_state == S_SCAN, CNT_W'(r_idx) < i_count)
    `NPS_ASSERT_IMPL(a_emit_below_count, i_clk, i_rst_n,
        r_state != S_IDLE, r_emit_cnt < i_count)

endmodule

// ===== src/nps_dp.sv =====
`include "assert_macros.svh"

module nps_dp #(
    parameter int MAX_PROCESSES = nps_pkg::MAX_PROCESSES_DEF,
    localparam int IDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1,
    localparam int CNT_W = $clog2(MAX_PROCESSES + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_higher_number_first,
    input  nps_pkg::t_in_item    i_in_data,
    input  nps_pkg::t_ctl_cmd    i_cmd,
    input  logic [IDX_W-1:0]     i_rd_idx,
    output nps_pkg::t_dp_status  o_status,
    output logic [CNT_W-1:0]     o_count,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output nps_pkg::t_out_item   o_out_data
);

    localparam int TIME_W = nps_pkg::TIME_W;

    nps_pkg::t_job             w_wr_job;
    nps_pkg::t_job             w_rd_job;
    logic                      w_wr_en;
    logic [CNT_W-1:0]          r_count;
    logic                      r_ovf;
    logic [MAX_PROCESSES-1:0]  r_done;
    logic [TIME_W-1:0]         r_time;
    logic                      r_rd_vld;
    logic [IDX_W-1:0]          r_rd_idx;

    logic                      r_best_found;
    logic [IDX_W-1:0]          r_best_idx;
    logic [nps_pkg::PRIO_W-1:0]  r_best_prio;
    logic [nps_pkg::ARR_W-1:0]   r_best_arr;
    logic [nps_pkg::BURST_W-1:0] r_best_burst;
    logic                      r_soon_found;
    logic [nps_pkg::ARR_W-1:0]   r_soon;

    logic                      r_out_vld;
    nps_pkg::t_out_item        r_out;

    logic                      w_first;
    logic                      w_pending;
    logic                      w_ready;
    logic                      w_better;
    logic                      w_take_best;
    logic                      w_take_soon;
    logic [TIME_W:0]           w_sum;
    logic [TIME_W-1:0]         w_finish;
    logic [IDX_W:0]            w_num;

    assign w_wr_en  = i_cmd.load && (r_count < CNT_W'(MAX_PROCESSES));
    assign w_wr_job = '{arrival_time: i_in_data.arrival_time,
                        burst_time:   i_in_data.burst_time,
                        job_priority: i_in_data.job_priority};

    nps_ram #(
        .WIDTH (nps_pkg::JOB_W),
        .DEPTH (MAX_PROCESSES)
    ) u_job_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_count[IDX_W-1:0]),
        .i_wr_data (w_wr_job),
        .i_rd_en   (i_cmd.rd_en),
        .i_rd_addr (i_rd_idx),
        .o_rd_data (w_rd_job)
    );

    assign w_first   = (r_rd_idx == '0);
    assign w_pending = !r_done[r_rd_idx];
    assign w_ready   = w_pending && (TIME_W'(w_rd_job.arrival_time) <= r_time);
    assign w_better  = (i_higher_number_first ? (w_rd_job.job_priority > r_best_prio)
                                              : (w_rd_job.job_priority < r_best_prio))
                    || ((w_rd_job.job_priority == r_best_prio)
                        && (w_rd_job.arrival_time < r_best_arr));
    assign w_take_best = r_rd_vld && w_ready && (w_first || !r_best_found || w_better);
    assign w_take_soon = r_rd_vld && w_pending
                      && (w_first || !r_soon_found || (w_rd_job.arrival_time < r_soon));

    assign w_sum    = {1'b0, r_time} + (TIME_W + 1)'(r_best_burst);
    assign w_finish = w_sum[TIME_W] ? nps_pkg::TIME_MAX : w_sum[TIME_W-1:0];
    assign w_num    = {1'b0, r_best_idx} + (IDX_W + 1)'(1);

    assign o_status.best_found = r_best_found;
    assign o_status.out_free   = !r_out_vld || i_out_ready;
    assign o_count     = r_count;
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_ovf        <= 1'b0;
            r_done       <= '0;
            r_time       <= '0;
            r_rd_vld     <= 1'b0;
            r_best_found <= 1'b0;
            r_soon_found <= 1'b0;
            r_out_vld    <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.rd_en;
            if (i_cmd.commit) begin
                r_out_vld <= 1'b1;
            end else if (o_out_valid && i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            if (i_cmd.load) begin
                if (w_wr_en) begin
                    r_count <= r_count + CNT_W'(1);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (r_rd_vld) begin
                if (w_first) begin
                    r_best_found <= w_ready;
                    r_soon_found <= w_pending;
                end else begin
                    r_best_found <= r_best_found || w_ready;
                    r_soon_found <= r_soon_found || w_pending;
                end
            end
            if (i_cmd.advance) begin
                r_time <= TIME_W'(r_soon);
            end
            if (i_cmd.commit) begin
                if (i_cmd.last_emit) begin
                    r_count <= '0;
                    r_ovf   <= 1'b0;
                    r_done  <= '0;
                    r_time  <= '0;
                end else begin
                    r_done[r_best_idx] <= 1'b1;
                    r_time             <= w_finish;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= i_rd_idx;
        if (w_take_best) begin
            r_best_idx   <= r_rd_idx;
            r_best_prio  <= w_rd_job.job_priority;
            r_best_arr   <= w_rd_job.arrival_time;
            r_best_burst <= w_rd_job.burst_time;
        end
        if (w_take_soon) begin
            r_soon <= w_rd_job.arrival_time;
        end
        if (i_cmd.commit) begin
            r_out.job_number        <= nps_pkg::JOBNUM_W'(w_num);
            r_out.start_time        <= r_time;
            r_out.finish_time       <= w_finish;
            r_out.final_entry       <= i_cmd.last_emit;
            r_out.capacity_overflow <= r_ovf;
        end
    end

    `NPS_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n,
        1'b1, r_count <= CNT_W'(MAX_PROCESSES))
    `NPS_ASSERT_IMPL(a_commit_pending, i_clk, i_rst_n,
        i_cmd.commit, !r_done[r_best_idx] && o_status.out_free)
    `NPS_ASSERT_NEXT(a_set_cleared, i_clk, i_rst_n,
        i_cmd.commit && i_cmd.last_emit, (r_count == '0) && (r_done == '0) && !r_ovf)

endmodule

// ===== src/nonpreemptive_priority_scheduler.sv =====
// Channel  | Handshake                     | Payload
// input    | i_in_valid / o_in_ready       | i_in_data  (nps_pkg::t_in_item)
// output   | o_out_valid / i_out_ready     | o_out_data (nps_pkg::t_out_item)
// config   | psel, penable, pwrite, pready | paddr, pwdata, prdata
//
// Jobs load only while idle; o_in_ready is low while a set is being scheduled.
// Each result comes from a scan with one job-table RAM read per stored entry,
// then a compare state and a decision state. An idle gap adds another scan.
// A result waits in the output register while the next decision is scanned;
// a full output register holds the decision. Reset is synchronous, active low.
module nonpreemptive_priority_scheduler #(
    parameter int MAX_PROCESSES = nps_pkg::MAX_PROCESSES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  nps_pkg::t_in_item              i_in_data,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output nps_pkg::t_out_item             o_out_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [nps_pkg::PADDR_W-1:0]    paddr,
    input  logic [nps_pkg::PDATA_W-1:0]    pwdata,
    output logic [nps_pkg::PDATA_W-1:0]    prdata,
    output logic                           pready
);

    localparam int IDX_W = (MAX_PROCESSES > 1) ? $clog2(MAX_PROCESSES) : 1;
    localparam int CNT_W = $clog2(MAX_PROCESSES + 1);

    logic                r_higher_number_first;
    nps_pkg::t_ctl_cmd   w_cmd;
    nps_pkg::t_dp_status w_status;
    logic [IDX_W-1:0]    w_rd_idx;
    logic [CNT_W-1:0]    w_count;
    logic                w_hnf_sel;

    assign pready    = 1'b1;
    assign w_hnf_sel = (paddr == nps_pkg::CFG_ADDR_HNF);
    assign prdata    = w_hnf_sel ? nps_pkg::PDATA_W'(r_higher_number_first) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_higher_number_first <= 1'b0;
        end else if (psel && penable && pwrite && pready && w_hnf_sel) begin
            r_higher_number_first <= pwdata[0];
        end
    end

    nps_ctrl #(
        .MAX_PROCESSES (MAX_PROCESSES)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_last_job (i_in_data.last_job),
        .o_in_ready (o_in_ready),
        .i_count    (w_count),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_rd_idx   (w_rd_idx)
    );

    nps_dp #(
        .MAX_PROCESSES (MAX_PROCESSES)
    ) u_dp (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_higher_number_first (r_higher_number_first),
        .i_in_data             (i_in_data),
        .i_cmd                 (w_cmd),
        .i_rd_idx              (w_rd_idx),
        .o_status              (w_status),
        .o_count               (w_count),
        .o_out_valid           (o_out_valid),
        .i_out_ready           (i_out_ready),
        .o_out_data            (o_out_data)
    );

endmodule
